// ===== hdl/prfl_pkg.sv =====
// Shared constants, register indexes and controller command type for the page frame table.
package prfl_pkg;

    localparam int PAGE_W      = 20;
    localparam int SLOT_W      = 4;
    localparam int COUNT_W     = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;
    localparam int FIU_W       = 5;

    localparam int FRAMES_DEFAULT = 16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_LRU_MODE      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAMES_IN_USE = 2'd1;

    localparam logic [FIU_W-1:0]   FIU_RESET = 5'd16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the incoming page number
        logic scan;    // register tag compare and group minimum results
        logic commit;  // update the frame table and load the result register
    } prfl_cmd_t;

endpackage

// ===== hdl/prfl_ctrl.sv =====
// Controller state machine for the page frame table: sequencing and handshakes.
module prfl_ctrl
    import prfl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output prfl_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   can_commit;

    assign can_commit = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan   = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (can_commit)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    in_ready       = 1'b1;
                    if (in_valid)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // A result is only committed when the output register is free or being drained.
    a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || out_ready))
        else $error("commit while result register is occupied");

    // The scan stage always hands over to the update stage.
    a_scan_then_update: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |=> state_reg == ST_UPDATE)
        else $error("scan not followed by update");

    // No new reference is taken while a scan is in flight.
    a_no_load_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> !in_ready && !cmd.load)
        else $error("reference taken during scan");

    // Every commit leaves a result waiting at the output.
    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("committed result not presented");

endmodule

// ===== hdl/prfl_dp.sv =====
// Datapath of the page frame table: frame registers, tag compare, minimum search, counters.
module prfl_dp
    import prfl_pkg::*;
#(
    parameter int FRAMES = FRAMES_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  prfl_cmd_t              cmd,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [PAGE_W-1:0]      page_number,
    output logic                   hit,
    output logic [SLOT_W-1:0]      slot,
    output logic                   evicted_valid,
    output logic [PAGE_W-1:0]      evicted_page,
    output logic [COUNT_W-1:0]     fault_count
);

    localparam int IW     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int GROUPS = (FRAMES + 7) / 8;
    localparam int CW     = $clog2(FRAMES + 1);
    localparam int NW     = (CW > FIU_W) ? CW : FIU_W;

    // Configuration.
    logic             lru_mode_reg;
    logic [FIU_W-1:0] fiu_reg;

    // Frame table.
    logic [PAGE_W-1:0]  page_reg  [FRAMES];
    logic [COUNT_W-1:0] stamp_reg [FRAMES];
    logic [FRAMES-1:0]  valid_reg;
    logic [COUNT_W-1:0] time_reg;
    logic [COUNT_W-1:0] faults_reg;

    logic [PAGE_W-1:0]  page_q_reg;

    // Scan stage results.
    logic               s1_hit_reg;
    logic [IW-1:0]      s1_hit_idx_reg;
    logic               s1_empty_reg;
    logic [IW-1:0]      s1_empty_idx_reg;
    logic [GROUPS-1:0]  grp_ok_reg;
    logic [COUNT_W-1:0] grp_stamp_reg [GROUPS];
    logic [IW-1:0]      grp_idx_reg   [GROUPS];

    logic [NW-1:0]      n_eff;
    logic [FRAMES-1:0]  active;
    logic               hit_c;
    logic [IW-1:0]      hit_idx_c;
    logic               empty_c;
    logic [IW-1:0]      empty_idx_c;
    logic [GROUPS-1:0]  grp_ok_c;
    logic [COUNT_W-1:0] grp_stamp_c [GROUPS];
    logic [IW-1:0]      grp_idx_c   [GROUPS];

    // Update stage signals.
    logic [IW-1:0]      min_idx_c;
    logic [COUNT_W-1:0] time_next;
    logic [COUNT_W-1:0] faults_next;
    logic [IW-1:0]      slot_c;
    logic [IW+SLOT_W-1:0] slot_wide;

    // Effective frame count, clamped to one and to FRAMES.
    always_comb
    begin
        n_eff = NW'(fiu_reg);
        if (fiu_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (NW'(fiu_reg) > NW'(FRAMES))
        begin
            n_eff = NW'(FRAMES);
        end
    end

    for (genvar i = 0; i < FRAMES; i++)
    begin : g_active
        assign active[i] = NW'(i) < n_eff;
    end

    // Lowest matching frame and lowest empty frame among those in use.
    always_comb
    begin
        hit_c       = 1'b0;
        hit_idx_c   = '0;
        empty_c     = 1'b0;
        empty_idx_c = '0;
        for (int i = FRAMES - 1; i >= 0; i--)
        begin
            if (active[i] && valid_reg[i] && page_reg[i] == page_q_reg)
            begin
                hit_c     = 1'b1;
                hit_idx_c = IW'(i);
            end
            if (active[i] && !valid_reg[i])
            begin
                empty_c     = 1'b1;
                empty_idx_c = IW'(i);
            end
        end
    end

    // First level of the minimum search: oldest stamp within each group of eight.
    for (genvar g = 0; g < GROUPS; g++)
    begin : g_group
        logic               gf;
        logic [COUNT_W-1:0] gs;
        logic [IW-1:0]      gi;
        always_comb
        begin
            gf = 1'b0;
            gs = '0;
            gi = '0;
            for (int k = 0; k < 8; k++)
            begin
                if (g * 8 + k < FRAMES)
                begin
                    if (active[g * 8 + k] && (!gf || stamp_reg[g * 8 + k] < gs))
                    begin
                        gf = 1'b1;
                        gs = stamp_reg[g * 8 + k];
                        gi = IW'(g * 8 + k);
                    end
                end
            end
        end
        assign grp_ok_c[g]    = gf;
        assign grp_stamp_c[g] = gs;
        assign grp_idx_c[g]   = gi;
    end

    // Second level: strict compare in ascending group order keeps the lowest index on ties.
    always_comb
    begin
        logic               mf;
        logic [COUNT_W-1:0] ms;
        mf        = 1'b0;
        ms        = '0;
        min_idx_c = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            if (grp_ok_reg[g] && (!mf || grp_stamp_reg[g] < ms))
            begin
                mf        = 1'b1;
                ms        = grp_stamp_reg[g];
                min_idx_c = grp_idx_reg[g];
            end
        end
    end

    assign time_next   = (time_reg == COUNT_MAX) ? time_reg : time_reg + COUNT_W'(1);
    assign faults_next = (faults_reg == COUNT_MAX) ? faults_reg : faults_reg + COUNT_W'(1);

    always_comb
    begin
        if (s1_hit_reg)
        begin
            slot_c = s1_hit_idx_reg;
        end
        else if (s1_empty_reg)
        begin
            slot_c = s1_empty_idx_reg;
        end
        else
        begin
            slot_c = min_idx_c;
        end
    end

    assign slot_wide = (IW + SLOT_W)'(slot_c);

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lru_mode_reg <= 1'b0;
            fiu_reg      <= FIU_RESET;
            valid_reg    <= '0;
            time_reg     <= '0;
            faults_reg   <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_LRU_MODE)
            begin
                lru_mode_reg <= cfg_data[0];
            end
            if (cfg_we && cfg_index == REG_FRAMES_IN_USE)
            begin
                fiu_reg <= cfg_data[FIU_W-1:0];
            end
            if (cmd.commit)
            begin
                time_reg <= time_next;
                if (!s1_hit_reg)
                begin
                    faults_reg        <= faults_next;
                    valid_reg[slot_c] <= 1'b1;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            page_q_reg <= page_number;
        end
        if (cmd.scan)
        begin
            s1_hit_reg       <= hit_c;
            s1_hit_idx_reg   <= hit_idx_c;
            s1_empty_reg     <= empty_c;
            s1_empty_idx_reg <= empty_idx_c;
            grp_ok_reg       <= grp_ok_c;
            grp_stamp_reg    <= grp_stamp_c;
            grp_idx_reg      <= grp_idx_c;
        end
        if (cmd.commit)
        begin
            if (s1_hit_reg)
            begin
                if (lru_mode_reg)
                begin
                    stamp_reg[slot_c] <= time_next;
                end
            end
            else
            begin
                page_reg[slot_c]  <= page_q_reg;
                stamp_reg[slot_c] <= time_next;
            end
            hit           <= s1_hit_reg;
            slot          <= slot_wide[SLOT_W-1:0];
            evicted_valid <= !s1_hit_reg && !s1_empty_reg;
            evicted_page  <= (!s1_hit_reg && !s1_empty_reg) ? page_reg[min_idx_c] : '0;
            fault_count   <= s1_hit_reg ? faults_reg : faults_next;
        end
    end

endmodule

// ===== hdl/page_replacement_fifo_lru.sv =====
// Top level of the page frame table with FIFO or LRU replacement.
//
// This block keeps a fully associative table of FRAMES page frames and takes one
// page reference per input transfer, returning exactly one result transfer per
// reference: whether the page was resident, the frame that holds it afterwards,
// the page evicted to make room (if any) and the running, saturating fault count.
// Register 0 selects the policy (0 first in first out, 1 least recently used) and
// register 1 sets how many frames are in use; zero acts as one and values above
// FRAMES act as FRAMES. Write the registers only while the block is idle. A
// reference passes through two steps: a scan that compares its tag against every
// frame in use and finds the oldest stamp within each group of eight frames, and
// an update that reduces the group results, updates the frame table and loads
// the result register. No new reference is taken during the scan; with the result
// side ready, the next one is taken in the same cycle as the previous result is
// loaded, so a waiting result does not block the input until the following update.
// The slot field carries the low four bits of the frame index.
module page_replacement_fifo_lru
    import prfl_pkg::*;
#(
    parameter int FRAMES = FRAMES_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [PAGE_W-1:0]      page_number,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   hit,
    output logic [SLOT_W-1:0]      slot,
    output logic                   evicted_valid,
    output logic [PAGE_W-1:0]      evicted_page,
    output logic [COUNT_W-1:0]     fault_count
);

    prfl_cmd_t cmd;

    // The controller sequences each reference and owns both handshakes.
    prfl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // The datapath holds the frame table, counters, configuration and result register.
    prfl_dp #(
        .FRAMES (FRAMES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .page_number   (page_number),
        .hit           (hit),
        .slot          (slot),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_count   (fault_count)
    );

endmodule
